/* sv/hwbc_pkg.sv */
// Shared definitions for the hashed two-way bank cache tag controller.
// Holds default geometry, the hash constants, the hash round and the
// command and status structs exchanged between the controller and datapath.
package hwbc_pkg;

  localparam int unsigned BankBitsDef = 6;
  localparam int unsigned SetBitsDef  = 12;
  localparam int unsigned AddrBitsDef = 22;

  localparam logic [31:0] HashMul   = 32'd2654435761;
  localparam int unsigned HashShift = 16;

  typedef struct packed {
    logic load;
    logic clr;
    logic mul1;
    logic mul2;
    logic rd;
    logic emit_recent;
    logic emit_resolve;
  } cmd_t;

  typedef struct packed {
    logic recent_hit;
    logic clr_last;
  } status_t;

  function automatic logic [31:0] hash_round(logic [31:0] x);
    logic [31:0] mixed;
    mixed = x ^ (x >> HashShift);
    return mixed * HashMul;
  endfunction

endpackage

/* sv/hashed_two_way_bank_cache_tags.sv */
// Top level of the hashed two-way bank cache tag controller.
// Instantiates hwbc_ctrl and hwbc_dpath; uses hwbc_pkg for defaults and types.
//
// Each accepted word is one byte address plus a random victim bit; one result
// word comes back per input. After reset the block runs a clearing pass that
// writes all 2**SET_BITS sets (4096 by default) of both tag memories, with the
// input stalled. Once its address is latched, an access to the most recently
// filled bank is answered from the recent-bank register; any other access goes
// on through one step per hash multiply round (two), the registered tag
// memory read and a step to compare and write the tag on a miss. One item is in
// flight at a time; a finished result waits in the output register, so the
// next address can be accepted while it is still stalled.
module hashed_two_way_bank_cache_tags #(
  parameter int unsigned BANK_BITS = hwbc_pkg::BankBitsDef,
  parameter int unsigned SET_BITS  = hwbc_pkg::SetBitsDef,
  parameter int unsigned ADDR_BITS = hwbc_pkg::AddrBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [ADDR_BITS-1:0] address_i,
  input  logic                 replace_way_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 hit_o,
  output logic                 way_o,
  output logic [SET_BITS-1:0]  set_index_o,
  output logic [BANK_BITS-1:0] byte_offset_o,
  output logic                 fill_request_o,
  output logic [ADDR_BITS-1:0] fill_base_o
);

  hwbc_pkg::cmd_t    cmd;
  hwbc_pkg::status_t status;

  hwbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  hwbc_dpath #(
    .BANK_BITS (BANK_BITS),
    .SET_BITS  (SET_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .address_i      (address_i),
    .replace_way_i  (replace_way_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .hit_o          (hit_o),
    .way_o          (way_o),
    .set_index_o    (set_index_o),
    .byte_offset_o  (byte_offset_o),
    .fill_request_o (fill_request_o),
    .fill_base_o    (fill_base_o)
  );

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr |-> in_stall_o)
    else $error("input accepted during tag clearing");

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_recent || cmd.emit_resolve) |-> (!out_valid_o || !out_stall_i))
    else $error("result overwrote a word still waiting at the output");

  a_fill_only_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(fill_request_o && hit_o))
    else $error("fill requested on a hit");

  a_fill_base_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fill_request_o) |-> (fill_base_o[BANK_BITS-1:0] == '0))
    else $error("fill base not aligned to a bank");

  a_emit_then_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_recent || cmd.emit_resolve) |=> out_valid_o)
    else $error("emitted result not presented");

endmodule

/* sv/hwbc_ctrl.sv */
// Sequencing state machine for the bank cache tag controller.
// Depends on hwbc_pkg for the command and status structs; drives the
// input stall, the output valid and the datapath commands.
module hwbc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  hwbc_pkg::status_t status_i,
  output hwbc_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] StClear   = 3'd0;
  localparam logic [2:0] StIdle    = 3'd1;
  localparam logic [2:0] StCheck   = 3'd2;
  localparam logic [2:0] StHash2   = 3'd3;
  localparam logic [2:0] StRead    = 3'd4;
  localparam logic [2:0] StResolve = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       emit;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign emit        = cmd_o.emit_recent || cmd_o.emit_resolve;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StClear: begin
        cmd_o.clr = 1'b1;
        if (status_i.clr_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StCheck;
        end
      end
      StCheck: begin
        cmd_o.mul1 = 1'b1;
        if (status_i.recent_hit) begin
          if (out_free) begin
            cmd_o.emit_recent = 1'b1;
            state_d           = StIdle;
          end
        end else begin
          state_d = StHash2;
        end
      end
      StHash2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = StRead;
      end
      StRead: begin
        cmd_o.rd = 1'b1;
        state_d  = StResolve;
      end
      StResolve: begin
        if (out_free) begin
          cmd_o.emit_resolve = 1'b1;
          state_d            = StIdle;
        end
      end
      default: begin
        state_d = StClear;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* sv/hwbc_dpath.sv */
// Datapath of the bank cache tag controller: hash rounds, the two tag
// memories with their clearing counter, the recent-bank register and the
// output word register. Depends on hwbc_pkg; driven by hwbc_ctrl commands.
module hwbc_dpath #(
  parameter int unsigned BANK_BITS = hwbc_pkg::BankBitsDef,
  parameter int unsigned SET_BITS  = hwbc_pkg::SetBitsDef,
  parameter int unsigned ADDR_BITS = hwbc_pkg::AddrBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [ADDR_BITS-1:0]  address_i,
  input  logic                  replace_way_i,
  input  hwbc_pkg::cmd_t        cmd_i,
  output hwbc_pkg::status_t     status_o,
  output logic                  hit_o,
  output logic                  way_o,
  output logic [SET_BITS-1:0]   set_index_o,
  output logic [BANK_BITS-1:0]  byte_offset_o,
  output logic                  fill_request_o,
  output logic [ADDR_BITS-1:0]  fill_base_o
);

  localparam int unsigned BankW  = ADDR_BITS - BANK_BITS;
  localparam int unsigned EntryW = BankW + 1;
  localparam int unsigned Sets   = 1 << SET_BITS;

  logic [ADDR_BITS-1:0] addr_q;
  logic                 repl_q;
  logic [31:0]          prod1_q;
  logic [31:0]          prod2;
  logic [SET_BITS-1:0]  set_q;
  logic [SET_BITS-1:0]  clr_cnt_q;
  logic [BankW-1:0]     bank;

  logic [BankW-1:0]     recent_bank_q;
  logic [SET_BITS-1:0]  recent_set_q;
  logic                 recent_way_q;
  logic                 recent_valid_q;

  logic [EntryW-1:0]    mem0 [Sets];
  logic [EntryW-1:0]    mem1 [Sets];
  logic [EntryW-1:0]    rd0_q, rd1_q;
  logic                 we0, we1;
  logic [SET_BITS-1:0]  waddr;
  logic [EntryW-1:0]    wdata;

  logic                 hit0, hit1, miss, new_way;

  assign bank = addr_q[ADDR_BITS-1:BANK_BITS];

  assign status_o.recent_hit = recent_valid_q && (bank == recent_bank_q);
  assign status_o.clr_last   = &clr_cnt_q;

  assign prod2 = hwbc_pkg::hash_round(prod1_q);

  assign hit0    = rd0_q[BankW] && (rd0_q[BankW-1:0] == bank);
  assign hit1    = rd1_q[BankW] && (rd1_q[BankW-1:0] == bank);
  assign miss    = !hit0 && !hit1;
  assign new_way = !repl_q;

  always_comb begin
    we0   = 1'b0;
    we1   = 1'b0;
    waddr = set_q;
    wdata = {1'b1, bank};
    if (cmd_i.clr) begin
      we0   = 1'b1;
      we1   = 1'b1;
      waddr = clr_cnt_q;
      wdata = '0;
    end else if (cmd_i.emit_resolve && miss) begin
      we0 = !new_way;
      we1 = new_way;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we0) begin
      mem0[waddr] <= wdata;
    end
    if (we1) begin
      mem1[waddr] <= wdata;
    end
    if (cmd_i.rd) begin
      rd0_q <= mem0[set_q];
      rd1_q <= mem1[set_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q <= address_i;
      repl_q <= replace_way_i;
    end
    if (cmd_i.mul1) begin
      prod1_q <= hwbc_pkg::hash_round(32'(bank));
    end
    if (cmd_i.mul2) begin
      set_q <= prod2[SET_BITS-1:0];
    end
    if (cmd_i.emit_recent) begin
      hit_o          <= 1'b1;
      way_o          <= recent_way_q;
      set_index_o    <= recent_set_q;
      byte_offset_o  <= addr_q[BANK_BITS-1:0];
      fill_request_o <= 1'b0;
      fill_base_o    <= '0;
    end else if (cmd_i.emit_resolve) begin
      hit_o          <= !miss;
      way_o          <= hit0 ? 1'b0 : (hit1 ? 1'b1 : new_way);
      set_index_o    <= set_q;
      byte_offset_o  <= addr_q[BANK_BITS-1:0];
      fill_request_o <= miss;
      fill_base_o    <= miss ? {bank, {BANK_BITS{1'b0}}} : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q      <= '0;
      recent_bank_q  <= '0;
      recent_set_q   <= '0;
      recent_way_q   <= 1'b0;
      recent_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cmd_i.emit_resolve && miss) begin
        recent_bank_q  <= bank;
        recent_set_q   <= set_q;
        recent_way_q   <= new_way;
        recent_valid_q <= 1'b1;
      end
    end
  end

endmodule

/* tb/hashed_two_way_bank_cache_tags_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the hashed two-way bank cache tag controller.
// Drives address words through a queue-fed driver, predicts every result word
// with its own tag model and checks it in a monitor; depends on hwbc_pkg and the top level.
module hashed_two_way_bank_cache_tags_tb;

  localparam int unsigned AddrW      = hwbc_pkg::AddrBitsDef;
  localparam int unsigned BankW      = hwbc_pkg::BankBitsDef;
  localparam int unsigned SetW       = hwbc_pkg::SetBitsDef;
  localparam int unsigned BankNumW   = AddrW - BankW;
  localparam int unsigned SetCount   = 1 << SetW;
  localparam int unsigned BankCount  = 1 << BankNumW;
  localparam logic [31:0] GoldenMul  = 32'd2654435761;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseWords = 440;

  typedef struct packed {
    logic [AddrW-1:0] address;
    logic             replace_way;
  } access_t;

  typedef struct packed {
    logic             hit;
    logic             way;
    logic [SetW-1:0]  set_index;
    logic [BankW-1:0] byte_offset;
    logic             fill_request;
    logic [AddrW-1:0] fill_base;
  } lookup_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i    = 1'b0;
  logic             in_stall_o;
  logic [AddrW-1:0] address_i     = '0;
  logic             replace_way_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i   = 1'b0;
  logic             hit_o;
  logic             way_o;
  logic [SetW-1:0]  set_index_o;
  logic [BankW-1:0] byte_offset_o;
  logic             fill_request_o;
  logic [AddrW-1:0] fill_base_o;

  access_t pending_words[$];
  lookup_t expected_lookups[$];

  logic [BankNumW-1:0] way0_tag [SetCount];
  logic [BankNumW-1:0] way1_tag [SetCount];
  bit                  way0_valid [SetCount];
  bit                  way1_valid [SetCount];
  logic [BankNumW-1:0] last_fill_bank  = '0;
  logic [SetW-1:0]     last_fill_set   = '0;
  logic                last_fill_way   = 1'b0;
  bit                  last_fill_valid = 1'b0;
  logic [SetW-1:0]     set_of [BankCount];

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          took_word = 1'b0;
  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned results_checked = 0;
  int unsigned accesses = 0;
  int unsigned recent_hits = 0;
  int unsigned tag_hits = 0;
  int unsigned fills = 0;

  hashed_two_way_bank_cache_tags dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .address_i     (address_i),
    .replace_way_i (replace_way_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .hit_o         (hit_o),
    .way_o         (way_o),
    .set_index_o   (set_index_o),
    .byte_offset_o (byte_offset_o),
    .fill_request_o(fill_request_o),
    .fill_base_o   (fill_base_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [SetW-1:0] bank_set(logic [BankNumW-1:0] bank);
    logic [31:0] h;
    h = 32'(bank);
    h = h ^ (h >> 16);
    h = h * GoldenMul;
    h = h ^ (h >> 16);
    h = h * GoldenMul;
    return h[SetW-1:0];
  endfunction

  function automatic access_t make_word(logic [BankNumW-1:0] bank, logic [BankW-1:0] offset,
                                        logic replace_way);
    access_t w;
    w.address = {bank, offset};
    w.replace_way = replace_way;
    return w;
  endfunction

  function automatic lookup_t predict_lookup(access_t acc);
    logic [BankNumW-1:0] bank;
    logic [SetW-1:0]     set_idx;
    lookup_t             res;
    bank = acc.address[AddrW-1:BankW];
    res = '0;
    res.byte_offset = acc.address[BankW-1:0];
    accesses++;
    if (last_fill_valid && bank == last_fill_bank) begin
      res.hit = 1'b1;
      res.way = last_fill_way;
      res.set_index = last_fill_set;
      recent_hits++;
      return res;
    end
    set_idx = bank_set(bank);
    res.set_index = set_idx;
    if (way0_valid[set_idx] && way0_tag[set_idx] == bank) begin
      res.hit = 1'b1;
      res.way = 1'b0;
      tag_hits++;
      return res;
    end
    if (way1_valid[set_idx] && way1_tag[set_idx] == bank) begin
      res.hit = 1'b1;
      res.way = 1'b1;
      tag_hits++;
      return res;
    end
    if (acc.replace_way) begin
      way0_tag[set_idx] = bank;
      way0_valid[set_idx] = 1'b1;
      res.way = 1'b0;
    end else begin
      way1_tag[set_idx] = bank;
      way1_valid[set_idx] = 1'b1;
      res.way = 1'b1;
    end
    last_fill_bank = bank;
    last_fill_set = set_idx;
    last_fill_way = res.way;
    last_fill_valid = 1'b1;
    res.fill_request = 1'b1;
    res.fill_base = {bank, {BankW{1'b0}}};
    fills++;
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= 20)
      $display("MISMATCH word %0d %s: got 0x%0h, expected 0x%0h", results_checked, field, got,
               want);
  endtask

  always @(negedge clk_i) begin : drive_words
    access_t next_word;
    out_stall_i <= ($urandom_range(99) < stall_pct);
    if (!in_valid_i || took_word) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
        next_word = pending_words.pop_front();
        in_valid_i <= 1'b1;
        address_i <= next_word.address;
        replace_way_i <= next_word.replace_way;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : watch_words
    access_t acc;
    lookup_t want;
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d words outstanding", cycles,
               expected_lookups.size());
      $display("Some tests failed");
      $finish;
    end
    took_word <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      acc.address = address_i;
      acc.replace_way = replace_way_i;
      expected_lookups.push_back(predict_lookup(acc));
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_lookups.size() == 0) begin
        report_mismatch("unexpected word, set_index", 32'(set_index_o), 32'h0);
      end else begin
        want = expected_lookups.pop_front();
        if (hit_o !== want.hit) report_mismatch("hit", 32'(hit_o), 32'(want.hit));
        if (way_o !== want.way) report_mismatch("way", 32'(way_o), 32'(want.way));
        if (set_index_o !== want.set_index)
          report_mismatch("set_index", 32'(set_index_o), 32'(want.set_index));
        if (byte_offset_o !== want.byte_offset)
          report_mismatch("byte_offset", 32'(byte_offset_o), 32'(want.byte_offset));
        if (fill_request_o !== want.fill_request)
          report_mismatch("fill_request", 32'(fill_request_o), 32'(want.fill_request));
        if (fill_base_o !== want.fill_base)
          report_mismatch("fill_base", 32'(fill_base_o), 32'(want.fill_base));
      end
      results_checked++;
    end
  end

  initial begin : stimulus
    logic [BankNumW-1:0] hot_banks[$];
    logic [BankNumW-1:0] probe;
    logic [BankNumW-1:0] last_bank;
    logic [BankNumW-1:0] bank;
    logic [BankNumW-1:0] bank_a;
    logic [BankNumW-1:0] bank_b;
    logic [BankNumW-1:0] bank_c;
    int unsigned         pick;
    int unsigned         found;

    rst_ni = 1'b0;
    for (int b = 0; b < BankCount; b++) set_of[b] = bank_set(BankNumW'(b));

    // Groups of three banks sharing one set force evictions in both ways.
    repeat (8) begin
      probe = BankNumW'($urandom);
      hot_banks.push_back(probe);
      found = 1;
      for (int b = 0; b < BankCount && found < 3; b++) begin
        if (BankNumW'(b) != probe && set_of[b] == set_of[probe]) begin
          hot_banks.push_back(BankNumW'(b));
          found++;
        end
      end
    end
    bank_a = hot_banks[0];
    bank_b = hot_banks[1];
    bank_c = hot_banks[2];

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    pending_words.push_back(make_word('0, '0, 1'b1));
    pending_words.push_back(make_word('0, '1, 1'b0));
    pending_words.push_back(make_word('1, '1, 1'b0));
    pending_words.push_back(make_word('0, 6'd17, 1'b0));
    pending_words.push_back(make_word('1, '0, 1'b1));
    pending_words.push_back(make_word(bank_a, 6'd0, 1'b1));
    pending_words.push_back(make_word(bank_b, 6'd1, 1'b0));
    pending_words.push_back(make_word(bank_a, 6'd5, 1'b0));
    pending_words.push_back(make_word(bank_b, 6'd2, 1'b1));
    pending_words.push_back(make_word(bank_a, 6'd63, 1'b0));
    pending_words.push_back(make_word(bank_c, 6'd9, 1'b1));
    pending_words.push_back(make_word(bank_a, 6'd10, 1'b0));
    pending_words.push_back(make_word(bank_c, 6'd11, 1'b0));
    pending_words.push_back(make_word(bank_b, 6'd12, 1'b1));
    pending_words.push_back(make_word(bank_a, 6'd13, 1'b1));
    pending_words.push_back(make_word(16'hAAAA, 6'h2A, 1'b1));
    pending_words.push_back(make_word(16'h5555, 6'h15, 1'b0));
    last_bank = 16'h5555;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 55; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 55; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      repeat (PhaseWords) begin
        pick = $urandom_range(99);
        if (pick < 25) bank = last_bank;
        else if (pick < 80) bank = hot_banks[$urandom_range(hot_banks.size() - 1)];
        else bank = BankNumW'($urandom);
        pending_words.push_back(make_word(bank, BankW'($urandom), 1'($urandom_range(1))));
        last_bank = bank;
      end
      while (pending_words.size() != 0 || in_valid_i || expected_lookups.size() != 0)
        @(negedge clk_i);
    end

    repeat (20) @(negedge clk_i);
    $display("Checked %0d result words from %0d accesses over four pacing phases:", results_checked,
             accesses);
    $display("%0d last-bank hits, %0d tag hits, %0d fills with evictions in shared sets.",
             recent_hits, tag_hits, fills);
    if (mismatches == 0 && expected_lookups.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
